// ===== rtl/core/cswin_pkg.sv =====
// ----------------------------------------------------------------------------
// cswin_pkg
// Shared types, constants and helpers for the calibration-state window
// statistics block.
// ----------------------------------------------------------------------------
package cswin_pkg;

    // Block dimensions
    localparam int NCAL             = 4;
    localparam int MAX_POINTS       = 16;
    localparam int CALIBRATED_STATE = 3;

    localparam int ST_W   = $clog2(NCAL);
    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int ENT_W  = 8;
    localparam int DUR_W  = 16;
    localparam int ROW_W  = NCAL * (ENT_W + DUR_W);
    localparam int WENT_W = 16;
    localparam int WDUR_W = DUR_W + PT_W;
    localparam int TOT_W  = WDUR_W + ST_W;
    localparam int WP_W   = 5;
    localparam int PCT_W  = 14;
    localparam int PROD_W = PCT_W + WDUR_W;

    // Serial divider geometry
    localparam int NUM_W = 36;
    localparam int DEN_W = TOT_W;
    localparam int QUO_W = 17;

    // Constants
    localparam logic [ENT_W-1:0] SAT8      = 8'hFF;
    localparam logic [DUR_W-1:0] SAT16     = 16'hFFFF;
    localparam int               PCT_SCALE = 100;

    // Divide by 60 * 1000 for x below 2**32: drop 5 low bits (60000 = 32 * 1875),
    // then multiply by ceil(2**38 / 1875) and keep the bits above 2**38
    localparam int          MIN_PRE_SH  = 5;
    localparam int          MIN_IN_W    = 27;
    localparam int          MIN_RECIP_W = 28;
    localparam logic [27:0] MIN_RECIP   = 28'd146601551;
    localparam int          MIN_POST_SH = 38;

    // Register reset values
    localparam logic [15:0]     PERIOD_RST = 16'd60;
    localparam logic [WP_W-1:0] WINDOW_RST = 5'd16;
    localparam logic [15:0]     MS_RST     = 16'd1000;
    localparam logic [6:0]      PCT_RST    = 7'd1;

    // Configuration register indexes
    typedef enum logic [3:0] {
        CFG_PERIOD_STEPS  = 4'd0,
        CFG_WINDOW_POINTS = 4'd1,
        CFG_MS_PER_STEP   = 4'd2,
        CFG_PCT_MULT      = 4'd3
    } cfg_idx_t;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_STEP    = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // Record kinds
    typedef enum logic {
        REC_SUMMARY = 1'b0,
        REC_STATE   = 1'b1
    } rec_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_ROT_READ,
        ST_ROT_SUB,
        ST_MIN_PREV,
        ST_MIN_PREV_WAIT,
        ST_MIN_CUR,
        ST_MIN_CUR_WAIT,
        ST_SUM_OUT,
        ST_SHARE_MUL,
        ST_SHARE_DIV,
        ST_SHARE_WAIT,
        ST_STATE_OUT
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    // Point memory control
    typedef struct packed {
        logic            clr_all;
        logic            wr_en;
        logic [PT_W-1:0] wr_row;
        logic            inv_en;
        logic [PT_W-1:0] inv_row;
        logic [PT_W-1:0] rd_row;
    } ptmem_ctl_t;

    // Saturate a quotient to 16 bits
    function automatic logic [15:0] sat_minutes(input logic [QUO_W-1:0] q);
        logic [15:0] r;
        if (q > QUO_W'(SAT16)) begin
            r = SAT16;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cswin_ptmem.sv =====
// ----------------------------------------------------------------------------
// cswin_ptmem
// Ring of per-period counters, one row per period holding the entry and
// duration counters of every state. Row valid bits make unwritten or cleared
// rows read as zero.
// ----------------------------------------------------------------------------
module cswin_ptmem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cswin_pkg::ptmem_ctl_t          ctl,
    input  logic [cswin_pkg::ROW_W-1:0]    wr_data,
    output logic [cswin_pkg::ROW_W-1:0]    rd_data
);

    logic [cswin_pkg::ROW_W-1:0]      mem [cswin_pkg::MAX_POINTS];
    logic [cswin_pkg::ROW_W-1:0]      rd_raw_reg;
    logic [cswin_pkg::MAX_POINTS-1:0] row_vld_reg;
    logic                             rd_vld_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_row] <= wr_data;
        end
        rd_raw_reg <= mem[ctl.rd_row];
    end

    // Row valid bits: set on write, drop on invalidate or clear
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_all) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= row_vld_reg[ctl.rd_row];
            if (ctl.wr_en) begin
                row_vld_reg[ctl.wr_row] <= 1'b1;
            end
            if (ctl.inv_en) begin
                row_vld_reg[ctl.inv_row] <= 1'b0;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// ===== rtl/core/cswin_div.sv =====
// ----------------------------------------------------------------------------
// cswin_div
// Restoring serial divider, one quotient bit per cycle. The caller keeps the
// quotient below 2**QUO_W.
// ----------------------------------------------------------------------------
module cswin_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  cswin_pkg::div_req_t req,
    output cswin_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(cswin_pkg::QUO_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [cswin_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [cswin_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [cswin_pkg::QUO_W-1:0]   low_reg, low_next;
    logic [cswin_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [cswin_pkg::DEN_W:0]     trial;
    logic                          ge;

    assign trial = {rem_reg, low_reg[cswin_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // Load on start, then shift one bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(cswin_pkg::QUO_W);
            rem_next  = cswin_pkg::DEN_W'(req.num[cswin_pkg::NUM_W-1:cswin_pkg::QUO_W]);
            low_next  = req.num[cswin_pkg::QUO_W-1:0];
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = ge ? cswin_pkg::DEN_W'(trial - {1'b0, den_reg})
                          : cswin_pkg::DEN_W'(trial);
            low_next = {low_reg[cswin_pkg::QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[cswin_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/core/calibration_state_window_stats_unit.sv =====
// ----------------------------------------------------------------------------
// calibration_state_window_stats_unit
// Sliding-window statistics over calibration-state samples, with per-period
// counters kept in a row memory and window totals in registers.
// ----------------------------------------------------------------------------
// Step: read the row, then write it back; when the period ends with the window
//   full, the oldest row is then read and retired. A dropped sample or a clear
//   is taken in idle. Restart: a write-back as for a step. Report: the summary,
//   then per state 1..NCAL-1 a share (zero for an empty window, else from the serial divider) and a state beat.
// One item at a time; the next beat is taken once the current one is done.
// Reset (synchronous, active low) clears the statistics registers, and the rows through per-row valid bits.
module calibration_state_window_stats_unit (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration
    input  logic              cfg_we,
    input  logic [3:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    // Input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic signed [4:0] s_cal_state,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_record,
    output logic [3:0]        m_state_index,
    output logic [15:0]       m_periods_done,
    output logic [15:0]       m_full_cal_count,
    output logic [15:0]       m_prev_cal_minutes,
    output logic [15:0]       m_cur_minutes,
    output logic [15:0]       m_init_count,
    output logic [13:0]       m_duration_share,
    output logic [15:0]       m_entered_count,
    output logic              m_last
);

    localparam int NCAL  = cswin_pkg::NCAL;
    localparam int ST_W  = cswin_pkg::ST_W;
    localparam int PT_W  = cswin_pkg::PT_W;
    localparam int ENT_W = cswin_pkg::ENT_W;
    localparam int DUR_W = cswin_pkg::DUR_W;
    localparam int WE_W  = cswin_pkg::WENT_W;
    localparam int WD_W  = cswin_pkg::WDUR_W;
    localparam int TOT_W = cswin_pkg::TOT_W;
    localparam int WP_W  = cswin_pkg::WP_W;
    localparam int MR_W  = cswin_pkg::MIN_IN_W + cswin_pkg::MIN_RECIP_W;

    // Configuration registers
    logic [15:0]      period_reg, period_next;
    logic [WP_W-1:0]  window_reg, window_next;
    logic [15:0]      ms_reg, ms_next;
    logic [6:0]       pct_reg, pct_next;

    // Statistics state
    cswin_pkg::state_t state_reg, state_next;
    logic [ST_W-1:0]  cur_st_reg, cur_st_next;
    logic [15:0]      cur_run_reg, cur_run_next;
    logic [15:0]      prev_full_reg, prev_full_next;
    logic [15:0]      full_ent_reg, full_ent_next;
    logic [15:0]      period_cnt_reg, period_cnt_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [PT_W-1:0]  ring_reg, ring_next;
    logic [WP_W-1:0]  used_reg, used_next;
    logic [WE_W-1:0]  went_reg [NCAL];
    logic [WE_W-1:0]  went_next [NCAL];
    logic [WD_W-1:0]  wdur_reg [NCAL];
    logic [WD_W-1:0]  wdur_next [NCAL];
    logic [TOT_W-1:0] total_reg, total_next;

    // Item in flight
    logic [ST_W-1:0]  samp_reg, samp_next;
    logic             ent_reg, ent_next;
    logic             rot_reg, rot_next;
    logic [PT_W-1:0]  nx_reg, nx_next;
    logic [ST_W-1:0]  j_reg, j_next;
    logic [15:0]      prev_min_reg, prev_min_next;
    logic [15:0]      cur_min_reg, cur_min_next;
    logic [cswin_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [13:0]      share_reg, share_next;

    // Output stage
    logic             m_valid_reg, m_valid_next;
    logic             o_record_reg, o_record_next;
    logic [3:0]       o_idx_reg, o_idx_next;
    logic [15:0]      o_pd_reg, o_pd_next;
    logic [15:0]      o_fc_reg, o_fc_next;
    logic [15:0]      o_pm_reg, o_pm_next;
    logic [15:0]      o_cm_reg, o_cm_next;
    logic [15:0]      o_ic_reg, o_ic_next;
    logic [13:0]      o_sh_reg, o_sh_next;
    logic [15:0]      o_ec_reg, o_ec_next;
    logic             o_last_reg, o_last_next;

    // Submodule links
    cswin_pkg::ptmem_ctl_t mem_ctl;
    logic [cswin_pkg::ROW_W-1:0] mem_wdata;
    logic [cswin_pkg::ROW_W-1:0] mem_rdata;
    cswin_pkg::div_req_t   div_req;
    cswin_pkg::div_rsp_t   div_rsp;

    // Helpers
    logic                 accept;
    logic                 out_free;
    logic [WP_W-1:0]      eff_w;
    logic [WP_W-1:0]      ring_inc;
    logic [PT_W-1:0]      nx_calc;
    logic [5:0]           samp_wide;
    logic [15:0]          elapsed_inc;
    logic [ENT_W-1:0]     row_ent;
    logic [DUR_W-1:0]     row_dur;
    logic [15:0]          min_src;
    logic [31:0]          min_prod;
    logic [MR_W-1:0]      min_recip;
    logic [cswin_pkg::QUO_W-1:0] min_quo;
    logic [cswin_pkg::PCT_W-1:0] pct100;
    logic [DUR_W+1:0]     row_dur_sum;

    cswin_ptmem u_ptmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    cswin_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Clamp the window size into 1..MAX_POINTS
    always_comb begin
        if (window_reg == '0) begin
            eff_w = WP_W'(1);
        end else if (window_reg > WP_W'(cswin_pkg::MAX_POINTS)) begin
            eff_w = WP_W'(cswin_pkg::MAX_POINTS);
        end else begin
            eff_w = window_reg;
        end
    end

    assign ring_inc    = WP_W'(ring_reg) + 1'b1;
    assign nx_calc     = (ring_inc >= eff_w) ? '0 : ring_inc[PT_W-1:0];
    assign samp_wide   = 6'(s_cal_state) + 6'd1;
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign row_ent     = mem_rdata[ENT_W*samp_reg +: ENT_W];
    assign row_dur     = mem_rdata[NCAL*ENT_W + DUR_W*samp_reg +: DUR_W];
    assign min_src     = (state_reg == cswin_pkg::ST_MIN_PREV) ? prev_full_reg : cur_run_reg;
    assign min_prod    = 32'(min_src) * 32'(ms_reg);
    assign pct100      = cswin_pkg::PCT_W'(pct_reg) * cswin_pkg::PCT_W'(cswin_pkg::PCT_SCALE);

    // Minutes from the registered step-times-ms product
    assign min_recip = MR_W'(prod_reg[cswin_pkg::MIN_PRE_SH +: cswin_pkg::MIN_IN_W]) *
                       MR_W'(cswin_pkg::MIN_RECIP);
    assign min_quo   = min_recip[cswin_pkg::MIN_POST_SH +: cswin_pkg::QUO_W];

    // Total duration held in a retiring row
    always_comb begin
        row_dur_sum = '0;
        for (int k = 0; k < NCAL; k++) begin
            row_dur_sum = row_dur_sum + (DUR_W+2)'(mem_rdata[NCAL*ENT_W + DUR_W*k +: DUR_W]);
        end
    end

    // Sequencer: next state, state updates and memory / divider control
    always_comb begin
        period_next     = period_reg;
        window_next     = window_reg;
        ms_next         = ms_reg;
        pct_next        = pct_reg;
        state_next      = state_reg;
        cur_st_next     = cur_st_reg;
        cur_run_next    = cur_run_reg;
        prev_full_next  = prev_full_reg;
        full_ent_next   = full_ent_reg;
        period_cnt_next = period_cnt_reg;
        elapsed_next    = elapsed_reg;
        ring_next       = ring_reg;
        used_next       = used_reg;
        went_next       = went_reg;
        wdur_next       = wdur_reg;
        total_next      = total_reg;
        samp_next       = samp_reg;
        ent_next        = ent_reg;
        rot_next        = rot_reg;
        nx_next         = nx_reg;
        j_next          = j_reg;
        prev_min_next   = prev_min_reg;
        cur_min_next    = cur_min_reg;
        prod_next       = prod_reg;
        share_next      = share_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        o_record_next   = o_record_reg;
        o_idx_next      = o_idx_reg;
        o_pd_next       = o_pd_reg;
        o_fc_next       = o_fc_reg;
        o_pm_next       = o_pm_reg;
        o_cm_next       = o_cm_reg;
        o_ic_next       = o_ic_reg;
        o_sh_next       = o_sh_reg;
        o_ec_next       = o_ec_reg;
        o_last_next     = o_last_reg;
        s_ready         = 1'b0;
        mem_ctl         = '0;
        mem_ctl.rd_row  = ring_reg;
        mem_wdata       = mem_rdata;
        div_req         = '0;

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                cswin_pkg::CFG_PERIOD_STEPS:  period_next = cfg_wdata;
                cswin_pkg::CFG_WINDOW_POINTS: window_next = cfg_wdata[WP_W-1:0];
                cswin_pkg::CFG_MS_PER_STEP:   ms_next     = cfg_wdata;
                cswin_pkg::CFG_PCT_MULT:      pct_next    = cfg_wdata[6:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            cswin_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    unique case (s_kind)
                        cswin_pkg::KIND_STEP: begin
                            // Drop samples outside -1..NCAL-2; the state index is the sample plus one
                            if (samp_wide <= 6'(NCAL - 1)) begin
                                samp_next = samp_wide[ST_W-1:0];
                                ent_next  = (cur_st_reg != samp_wide[ST_W-1:0]);
                                if (cur_st_reg != samp_wide[ST_W-1:0]) begin
                                    if (cur_st_reg == ST_W'(cswin_pkg::CALIBRATED_STATE)) begin
                                        prev_full_next = cur_run_reg;
                                    end
                                    if (samp_wide[ST_W-1:0] ==
                                        ST_W'(cswin_pkg::CALIBRATED_STATE) &&
                                        full_ent_reg != cswin_pkg::SAT16) begin
                                        full_ent_next = full_ent_reg + 1'b1;
                                    end
                                    cur_run_next = 16'd1;
                                    cur_st_next  = samp_wide[ST_W-1:0];
                                end else if (cur_run_reg != cswin_pkg::SAT16) begin
                                    cur_run_next = cur_run_reg + 1'b1;
                                end
                                if (elapsed_inc == period_reg) begin
                                    rot_next     = 1'b1;
                                    elapsed_next = '0;
                                    if (period_cnt_reg != cswin_pkg::SAT16) begin
                                        period_cnt_next = period_cnt_reg + 1'b1;
                                    end
                                end else begin
                                    rot_next     = 1'b0;
                                    elapsed_next = elapsed_inc;
                                end
                                state_next = cswin_pkg::ST_MODIFY;
                            end
                        end
                        cswin_pkg::KIND_REPORT: begin
                            state_next = cswin_pkg::ST_MIN_PREV;
                        end
                        cswin_pkg::KIND_RESTART: begin
                            samp_next  = '0;
                            ent_next   = 1'b1;
                            rot_next   = 1'b0;
                            state_next = cswin_pkg::ST_MODIFY;
                        end
                        cswin_pkg::KIND_CLEAR: begin
                            cur_st_next     = '0;
                            cur_run_next    = '0;
                            prev_full_next  = '0;
                            full_ent_next   = '0;
                            period_cnt_next = '0;
                            elapsed_next    = '0;
                            ring_next       = '0;
                            used_next       = WP_W'(1);
                            total_next      = '0;
                            for (int k = 0; k < NCAL; k++) begin
                                went_next[k] = '0;
                                wdur_next[k] = '0;
                            end
                            mem_ctl.clr_all = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // Count the sample into the current row and write it back
            cswin_pkg::ST_MODIFY: begin
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_row = ring_reg;
                if (ent_reg && row_ent != cswin_pkg::SAT8) begin
                    mem_wdata[ENT_W*samp_reg +: ENT_W] = row_ent + 1'b1;
                    went_next[samp_reg] = went_reg[samp_reg] + 1'b1;
                end
                if (samp_reg != '0 && row_dur != cswin_pkg::SAT16) begin
                    mem_wdata[NCAL*ENT_W + DUR_W*samp_reg +: DUR_W] = row_dur + 1'b1;
                    wdur_next[samp_reg] = wdur_reg[samp_reg] + 1'b1;
                    total_next          = total_reg + 1'b1;
                end
                state_next = cswin_pkg::ST_IDLE;
                if (rot_reg) begin
                    if (used_reg >= eff_w) begin
                        nx_next    = nx_calc;
                        state_next = cswin_pkg::ST_ROT_READ;
                    end else begin
                        used_next = used_reg + 1'b1;
                        ring_next = nx_calc;
                    end
                end
            end

            // Fetch the oldest row after the write has landed
            cswin_pkg::ST_ROT_READ: begin
                mem_ctl.rd_row = nx_reg;
                state_next     = cswin_pkg::ST_ROT_SUB;
            end

            // Retire the oldest row from the totals
            cswin_pkg::ST_ROT_SUB: begin
                for (int k = 0; k < NCAL; k++) begin
                    went_next[k] = went_reg[k] - WE_W'(mem_rdata[ENT_W*k +: ENT_W]);
                    wdur_next[k] = wdur_reg[k] -
                                   WD_W'(mem_rdata[NCAL*ENT_W + DUR_W*k +: DUR_W]);
                end
                total_next      = total_reg - TOT_W'(row_dur_sum);
                mem_ctl.inv_en  = 1'b1;
                mem_ctl.inv_row = nx_reg;
                ring_next       = nx_reg;
                state_next      = cswin_pkg::ST_IDLE;
            end

            // Register the product, then scale it to minutes
            cswin_pkg::ST_MIN_PREV: begin
                prod_next  = cswin_pkg::PROD_W'(min_prod);
                state_next = cswin_pkg::ST_MIN_PREV_WAIT;
            end

            cswin_pkg::ST_MIN_PREV_WAIT: begin
                prev_min_next = cswin_pkg::sat_minutes(min_quo);
                state_next    = cswin_pkg::ST_MIN_CUR;
            end

            cswin_pkg::ST_MIN_CUR: begin
                prod_next  = cswin_pkg::PROD_W'(min_prod);
                state_next = cswin_pkg::ST_MIN_CUR_WAIT;
            end

            cswin_pkg::ST_MIN_CUR_WAIT: begin
                cur_min_next = cswin_pkg::sat_minutes(min_quo);
                state_next   = cswin_pkg::ST_SUM_OUT;
            end

            // Emit the summary beat
            cswin_pkg::ST_SUM_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_record_next = cswin_pkg::REC_SUMMARY;
                    o_idx_next    = '0;
                    o_pd_next     = period_cnt_reg;
                    o_fc_next     = full_ent_reg;
                    o_pm_next     = prev_min_reg;
                    o_cm_next     = cur_min_reg;
                    o_ic_next     = went_reg[0];
                    o_sh_next     = '0;
                    o_ec_next     = '0;
                    o_last_next   = 1'b0;
                    j_next        = ST_W'(1);
                    state_next    = cswin_pkg::ST_SHARE_MUL;
                end
            end

            cswin_pkg::ST_SHARE_MUL: begin
                prod_next  = cswin_pkg::PROD_W'(pct100) * cswin_pkg::PROD_W'(wdur_reg[j_reg]);
                state_next = cswin_pkg::ST_SHARE_DIV;
            end

            // Rounded share; an empty window gives zero
            cswin_pkg::ST_SHARE_DIV: begin
                if (total_reg == '0) begin
                    share_next = '0;
                    state_next = cswin_pkg::ST_STATE_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = cswin_pkg::NUM_W'(prod_reg) +
                                    cswin_pkg::NUM_W'(total_reg >> 1);
                    div_req.den   = total_reg;
                    state_next    = cswin_pkg::ST_SHARE_WAIT;
                end
            end

            cswin_pkg::ST_SHARE_WAIT: begin
                if (div_rsp.done) begin
                    share_next = div_rsp.quo[13:0];
                    state_next = cswin_pkg::ST_STATE_OUT;
                end
            end

            // Emit one per-state beat
            cswin_pkg::ST_STATE_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_record_next = cswin_pkg::REC_STATE;
                    o_idx_next    = 4'(j_reg);
                    o_pd_next     = '0;
                    o_fc_next     = '0;
                    o_pm_next     = '0;
                    o_cm_next     = '0;
                    o_ic_next     = '0;
                    o_sh_next     = share_reg;
                    o_ec_next     = went_reg[j_reg];
                    o_last_next   = (j_reg == ST_W'(NCAL - 1));
                    if (j_reg == ST_W'(NCAL - 1)) begin
                        state_next = cswin_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = cswin_pkg::ST_SHARE_MUL;
                    end
                end
            end

            default: state_next = cswin_pkg::ST_IDLE;
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= cswin_pkg::PERIOD_RST;
            window_reg     <= cswin_pkg::WINDOW_RST;
            ms_reg         <= cswin_pkg::MS_RST;
            pct_reg        <= cswin_pkg::PCT_RST;
            state_reg      <= cswin_pkg::ST_IDLE;
            cur_st_reg     <= '0;
            cur_run_reg    <= '0;
            prev_full_reg  <= '0;
            full_ent_reg   <= '0;
            period_cnt_reg <= '0;
            elapsed_reg    <= '0;
            ring_reg       <= '0;
            used_reg       <= WP_W'(1);
            total_reg      <= '0;
            for (int k = 0; k < NCAL; k++) begin
                went_reg[k] <= '0;
                wdur_reg[k] <= '0;
            end
            m_valid_reg    <= 1'b0;
        end else begin
            period_reg     <= period_next;
            window_reg     <= window_next;
            ms_reg         <= ms_next;
            pct_reg        <= pct_next;
            state_reg      <= state_next;
            cur_st_reg     <= cur_st_next;
            cur_run_reg    <= cur_run_next;
            prev_full_reg  <= prev_full_next;
            full_ent_reg   <= full_ent_next;
            period_cnt_reg <= period_cnt_next;
            elapsed_reg    <= elapsed_next;
            ring_reg       <= ring_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            went_reg       <= went_next;
            wdur_reg       <= wdur_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        samp_reg     <= samp_next;
        ent_reg      <= ent_next;
        rot_reg      <= rot_next;
        nx_reg       <= nx_next;
        j_reg        <= j_next;
        prev_min_reg <= prev_min_next;
        cur_min_reg  <= cur_min_next;
        prod_reg     <= prod_next;
        share_reg    <= share_next;
        o_record_reg <= o_record_next;
        o_idx_reg    <= o_idx_next;
        o_pd_reg     <= o_pd_next;
        o_fc_reg     <= o_fc_next;
        o_pm_reg     <= o_pm_next;
        o_cm_reg     <= o_cm_next;
        o_ic_reg     <= o_ic_next;
        o_sh_reg     <= o_sh_next;
        o_ec_reg     <= o_ec_next;
        o_last_reg   <= o_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_record           = o_record_reg;
    assign m_state_index      = o_idx_reg;
    assign m_periods_done     = o_pd_reg;
    assign m_full_cal_count   = o_fc_reg;
    assign m_prev_cal_minutes = o_pm_reg;
    assign m_cur_minutes      = o_cm_reg;
    assign m_init_count       = o_ic_reg;
    assign m_duration_share   = o_sh_reg;
    assign m_entered_count    = o_ec_reg;
    assign m_last             = o_last_reg;

    // Window total tracks the per-state durations
    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        TOT_W'(wdur_reg[1]) + TOT_W'(wdur_reg[2]) + TOT_W'(wdur_reg[3]) == total_reg)
        else $error("window total out of step with state durations");

    // State zero never accumulates duration
    a_idle_dur: assert property (@(posedge aclk) disable iff (!aresetn)
        wdur_reg[0] == '0)
        else $error("duration counted for state zero");

    // Points in use stay within the ring
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg >= WP_W'(1) && used_reg <= WP_W'(cswin_pkg::MAX_POINTS))
        else $error("points in use out of range");

    // Divider finishes only while a share waits on it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == cswin_pkg::ST_SHARE_WAIT))
        else $error("divider result with no report waiting");

    // The read of a retiring row is always followed by its retirement
    a_rot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cswin_pkg::ST_ROT_READ |=> state_reg == cswin_pkg::ST_ROT_SUB)
        else $error("row retirement sequence broken");

endmodule

// ===== tb/sv/calibration_state_window_stats_unit_test.sv =====
// ----------------------------------------------------------------------------
// calibration_state_window_stats_unit_test
// Self-checking bench for the calibration-state window statistics unit. A
// queue-fed driver sends step, report, restart and clear beats in bursts. A
// monitor checks each report record, taken by a stalling receiver, with a built-in
// predictor of the window statistics. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module calibration_state_window_stats_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NCAL         = cswin_pkg::NCAL;
    localparam int          MAX_POINTS   = cswin_pkg::MAX_POINTS;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          STALL_LIMIT  = 4000;
    localparam logic [3:0]  CFG_UNUSED   = 4'd9;

    typedef struct {
        cswin_pkg::kind_t  kind;
        logic signed [4:0] cs;
    } sample_beat_t;

    typedef struct {
        logic        record;
        logic [3:0]  state_index;
        logic [15:0] periods_done;
        logic [15:0] full_cal_count;
        logic [15:0] prev_cal_minutes;
        logic [15:0] cur_minutes;
        logic [15:0] init_count;
        logic [13:0] duration_share;
        logic [15:0] entered_count;
        logic        last;
    } stats_rec_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [3:0]        cfg_index = '0;
    logic [15:0]       cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_kind = '0;
    logic signed [4:0] s_cal_state = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_record;
    logic [3:0]        m_state_index;
    logic [15:0]       m_periods_done, m_full_cal_count, m_prev_cal_minutes;
    logic [15:0]       m_cur_minutes, m_init_count, m_entered_count;
    logic [13:0]       m_duration_share;
    logic              m_last;

    calibration_state_window_stats_unit u_top (.*);

    always #10 aclk = ~aclk;

    // Predictor registers and state
    logic [15:0] prd_period = 16'd60;
    logic [4:0]  prd_window = 5'd16;
    logic [15:0] prd_ms = 16'd1000;
    logic [6:0]  prd_pct = 7'd1;

    int unsigned cur_st, cur_run, prev_full, full_ent, periods, elapsed, ring, used;
    int unsigned win_ent [NCAL];
    int unsigned win_dur [NCAL];
    int unsigned win_tot;
    int unsigned pt_ent [MAX_POINTS][NCAL];
    int unsigned pt_dur [MAX_POINTS][NCAL];

    sample_beat_t pending_beats [$];
    stats_rec_t   expected_recs [$];
    int           errors = 0;
    int unsigned  in_beats = 0;
    int unsigned  out_beats = 0;

    function automatic int unsigned sat_inc(int unsigned v);
        return (v < 32'hFFFF) ? v + 1 : v;
    endfunction

    function automatic logic [15:0] steps_to_minutes(int unsigned steps);
        longint unsigned u;
        u = longint'(steps) * prd_ms / 60 / 1000;
        return (u > 64'hFFFF) ? 16'hFFFF : u[15:0];
    endfunction

    task automatic clear_stats();
        cur_st = 0; cur_run = 0; prev_full = 0; full_ent = 0;
        periods = 0; elapsed = 0; ring = 0; used = 1; win_tot = 0;
        foreach (win_ent[s]) begin
            win_ent[s] = 0;
            win_dur[s] = 0;
        end
        foreach (pt_ent[p, s]) begin
            pt_ent[p][s] = 0;
            pt_dur[p][s] = 0;
        end
    endtask

    task automatic tally_sample(int unsigned st, bit entered);
        int unsigned p;
        p = ring % MAX_POINTS;
        if (entered && pt_ent[p][st] < 8'hFF) begin
            pt_ent[p][st]++;
            win_ent[st]++;
        end
        if (st != 0 && pt_dur[p][st] < 16'hFFFF) begin
            pt_dur[p][st]++;
            win_dur[st]++;
            win_tot++;
        end
    endtask

    task automatic rotate_ring();
        int unsigned w, nx;
        w = (prd_window < 1) ? 1 : (prd_window > MAX_POINTS) ? MAX_POINTS : prd_window;
        nx = ring + 1;
        if (nx >= w) nx = 0;
        if (used >= w) begin
            for (int s = 0; s < NCAL; s++) begin
                win_tot    -= pt_dur[nx][s];
                win_dur[s] -= pt_dur[nx][s];
                win_ent[s] -= pt_ent[nx][s];
                pt_dur[nx][s] = 0;
                pt_ent[nx][s] = 0;
            end
        end else begin
            used++;
        end
        ring = nx;
    endtask

    // Advance the predicted statistics by one accepted beat
    task automatic predict_beat(sample_beat_t b);
        int         v;
        bit         change;
        stats_rec_t r;
        longint unsigned share;
        case (b.kind)
            cswin_pkg::KIND_STEP: begin
                v = int'(b.cs) + 1;
                if (v >= 0 && v <= NCAL - 1) begin
                    change = (cur_st != v);
                    if (change) begin
                        if (cur_st == cswin_pkg::CALIBRATED_STATE) prev_full = cur_run;
                        if (v == cswin_pkg::CALIBRATED_STATE) full_ent = sat_inc(full_ent);
                        cur_run = 0;
                        cur_st = v;
                    end
                    tally_sample(v, change);
                    cur_run = sat_inc(cur_run);
                    elapsed = (elapsed + 1) & 32'hFFFF;
                    if (elapsed == prd_period) begin
                        rotate_ring();
                        periods = sat_inc(periods);
                        elapsed = 0;
                    end
                end
            end
            cswin_pkg::KIND_RESTART: tally_sample(0, 1'b1);
            cswin_pkg::KIND_CLEAR:   clear_stats();
            default: begin
                r = '{default: '0};
                r.record           = cswin_pkg::REC_SUMMARY;
                r.periods_done     = periods[15:0];
                r.full_cal_count   = full_ent[15:0];
                r.prev_cal_minutes = steps_to_minutes(prev_full);
                r.cur_minutes      = steps_to_minutes(cur_run);
                r.init_count       = win_ent[0][15:0];
                expected_recs.push_back(r);
                for (int j = 1; j < NCAL; j++) begin
                    share = 0;
                    if (win_tot != 0)
                        share = (64'd100 * prd_pct * win_dur[j] + win_tot / 2) / win_tot;
                    r = '{default: '0};
                    r.record         = cswin_pkg::REC_STATE;
                    r.state_index    = j[3:0];
                    r.duration_share = share[13:0];
                    r.entered_count  = win_ent[j][15:0];
                    r.last           = (j == NCAL - 1);
                    expected_recs.push_back(r);
                end
            end
        endcase
    endtask

    // Driver: bursts of beats separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    sample_beat_t cur_beat;

    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_beat(cur_beat);
                in_beats++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    s_kind <= cur_beat.kind;
                    s_cal_state <= cur_beat.cs;
                    next_valid = 1'b1;
                    burst_left--;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Receiver stall pattern: free-running, random, or periodic
    int unsigned rx_cycle = 0;
    int          rx_mode = 0;

    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (rx_cycle % 5) < 2;
        endcase
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Monitor: compare each record beat with the oldest expectation
    always @(posedge aclk) begin
        stats_rec_t e;
        if (aresetn && m_valid && m_ready) begin
            out_beats++;
            if (expected_recs.size() == 0) begin
                $display("%0t: unexpected record beat, record %0d state %0d",
                         $time, m_record, m_state_index);
                errors++;
            end else begin
                e = expected_recs.pop_front();
                check_field("record", 16'(e.record), 16'(m_record));
                check_field("state_index", 16'(e.state_index), 16'(m_state_index));
                check_field("periods_done", e.periods_done, m_periods_done);
                check_field("full_cal_count", e.full_cal_count, m_full_cal_count);
                check_field("prev_cal_minutes", e.prev_cal_minutes, m_prev_cal_minutes);
                check_field("cur_minutes", e.cur_minutes, m_cur_minutes);
                check_field("init_count", e.init_count, m_init_count);
                check_field("duration_share", 16'(e.duration_share),
                            16'(m_duration_share));
                check_field("entered_count", e.entered_count, m_entered_count);
                check_field("last", 16'(e.last), 16'(m_last));
            end
        end
    end

    // Watchdog on cycles with no beat moving
    int          idle_cycles = 0;
    int unsigned seen_beats = 0;

    always @(posedge aclk) begin
        #1;
        if (in_beats + out_beats != seen_beats) begin
            seen_beats = in_beats + out_beats;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("calibration_state_window_stats_unit_test NOT OK");
            $finish;
        end
    end

    task automatic queue_beat(cswin_pkg::kind_t k, int cs);
        sample_beat_t b;
        b.kind = k;
        b.cs = cs[4:0];
        pending_beats.push_back(b);
    endtask

    // Mostly runs of valid states, with noise, restarts, reports and clears
    task automatic queue_random(int n);
        int made, r, st, len;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                st = $urandom_range(0, NCAL - 1) - 1;
                len = $urandom_range(1, 6);
                repeat (len) queue_beat(cswin_pkg::KIND_STEP, st);
                made += len;
            end else begin
                if (r < 75)      queue_beat(cswin_pkg::KIND_STEP, $urandom_range(0, 31));
                else if (r < 85) queue_beat(cswin_pkg::KIND_RESTART, $urandom_range(0, 31));
                else if (r < 97) queue_beat(cswin_pkg::KIND_REPORT, $urandom_range(0, 31));
                else             queue_beat(cswin_pkg::KIND_CLEAR, $urandom_range(0, 31));
                made++;
            end
        end
        queue_beat(cswin_pkg::KIND_REPORT, 0);
    endtask

    // Hold until the block has drained, then let it settle
    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_recs.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            cswin_pkg::CFG_PERIOD_STEPS:  prd_period = val;
            cswin_pkg::CFG_WINDOW_POINTS: prd_window = val[4:0];
            cswin_pkg::CFG_MS_PER_STEP:   prd_ms = val;
            cswin_pkg::CFG_PCT_MULT:      prd_pct = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int per, int win, int ms, int pct);
        write_reg(cswin_pkg::CFG_PERIOD_STEPS, per[15:0]);
        write_reg(cswin_pkg::CFG_WINDOW_POINTS, {11'($urandom_range(0, 2047)), win[4:0]});
        write_reg(cswin_pkg::CFG_MS_PER_STEP, ms[15:0]);
        write_reg(cswin_pkg::CFG_PCT_MULT, {9'($urandom_range(0, 511)), pct[6:0]});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        clear_stats();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty report, each state, out-of-range samples, restart, clear
        queue_beat(cswin_pkg::KIND_REPORT, 0);
        for (int s = -1; s < NCAL - 1; s++) queue_beat(cswin_pkg::KIND_STEP, s);
        queue_beat(cswin_pkg::KIND_STEP, NCAL - 1);
        queue_beat(cswin_pkg::KIND_STEP, -16);
        queue_beat(cswin_pkg::KIND_STEP, 15);
        queue_beat(cswin_pkg::KIND_STEP, -2);
        queue_beat(cswin_pkg::KIND_RESTART, 5);
        queue_beat(cswin_pkg::KIND_REPORT, -1);
        repeat (3) queue_beat(cswin_pkg::KIND_STEP, cswin_pkg::CALIBRATED_STATE - 1);
        queue_beat(cswin_pkg::KIND_STEP, 0);
        queue_beat(cswin_pkg::KIND_REPORT, 10);
        queue_beat(cswin_pkg::KIND_CLEAR, -7);
        queue_beat(cswin_pkg::KIND_REPORT, 0);
        wait_drained();

        set_regs(1, 1, 65535, 100);
        queue_random(70);
        wait_drained();
        set_regs(3, 0, 1, 127);
        queue_random(70);
        wait_drained();
        set_regs(5, 31, $urandom_range(1, 65535), $urandom_range(1, 100));
        queue_random(70);
        wait_drained();
        set_regs(2, 16, 60000, 50);
        queue_random(80);
        wait_drained();
        // Shrink the window while points are in use
        set_regs(2, 3, 1000, 7);
        write_reg(CFG_UNUSED, 16'hFFFF);
        @(posedge aclk);
        cfg_we <= 1'b0;
        queue_random(70);
        wait_drained();
        set_regs(0, 16, 1000, 1);
        queue_random(30);
        wait_drained();
        set_regs(60, 16, 1000, 1);
        queue_random(60);
        wait_drained();

        if (errors == 0) begin
            $display("calibration_state_window_stats_unit_test OK");
        end else begin
            $display("calibration_state_window_stats_unit_test NOT OK");
        end
        $finish;
    end

endmodule
